>>> sv/tlwi_pkg.sv
// Shared types, constants and helpers for the text line wrap indexer.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tlwi_pkg;

    localparam int OFFSET_BITS = 20;
    localparam int START_BITS  = 20;
    localparam int LNUM_BITS   = 20;
    localparam int LEN_BITS    = 8;
    localparam int MAX_RECS    = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] WIDTH_RESET  = 8'd41;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        logic [START_BITS-1:0] start;
        logic [LEN_BITS-1:0]   len;
        logic                  fin;
    } rec_t;

    // Records caused by one byte; count is 1..3 for anything queued
    typedef struct packed {
        logic [1:0]           count;
        logic [LNUM_BITS-1:0] base;
        rec_t [MAX_RECS-1:0]  recs;
    } bundle_t;

    function automatic offset_t sat_add(input offset_t a, input offset_t b);
        logic [OFFSET_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[OFFSET_BITS] ? OFFSET_MAX : s[OFFSET_BITS-1:0];
        end
    endfunction

    function automatic logic [START_BITS-1:0] to_start(input offset_t a);
        logic [OFFSET_BITS+START_BITS-1:0] ext;
        begin
            ext = {{START_BITS{1'b0}}, a};
            to_start = ext[START_BITS-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/tlwi_front.sv
// Front end: holds the stream state and line width, classifies each byte
// and builds the bundle of records it completes. Uses tlwi_pkg.
`default_nettype none

module tlwi_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_eof,
    input  wire logic             q_full,
    output logic                  push,
    output tlwi_pkg::bundle_t     push_bundle
);

    logic [7:0]                      width_reg;
    tlwi_pkg::offset_t               chunk_start_reg, chunk_start_next;
    tlwi_pkg::offset_t               byte_offset_reg, byte_offset_next;
    logic [7:0]                      chunk_count_reg, chunk_count_next;
    logic                            cr_held_reg, cr_held_next;
    logic [tlwi_pkg::LNUM_BITS-1:0]  lines_reg, lines_next;
    tlwi_pkg::bundle_t               bundle;
    logic                            accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;

    always_comb begin
        logic [7:0]        w;
        tlwi_pkg::offset_t cs;
        logic [7:0]        cc;
        logic [1:0]        n;
        w  = (width_reg == 8'd0) ? 8'd1 : width_reg;
        cs = chunk_start_reg;
        cc = chunk_count_reg;
        n  = 2'd0;
        bundle = '0;
        bundle.base = lines_reg;
        cr_held_next = cr_held_reg;
        byte_offset_next = tlwi_pkg::sat_add(byte_offset_reg, tlwi_pkg::offset_t'(1));

        if (in_byte == tlwi_pkg::CH_LF) begin
            cr_held_next = 1'b0;
            bundle.recs[0] = '{start: tlwi_pkg::to_start(cs), len: cc, fin: in_eof};
            n  = 2'd1;
            cs = byte_offset_next;
            cc = 8'd0;
        end else begin
            // held CR turns out to be an ordinary character
            if (cr_held_reg) begin
                if (cc >= w) begin
                    bundle.recs[n] = '{start: tlwi_pkg::to_start(cs), len: cc, fin: 1'b0};
                    n  = n + 2'd1;
                    cs = tlwi_pkg::sat_add(cs, tlwi_pkg::offset_t'(cc));
                    cc = 8'd0;
                end
                cc = cc + 8'd1;
                cr_held_next = 1'b0;
            end
            if (in_byte == tlwi_pkg::CH_CR) begin
                cr_held_next = !in_eof;
            end else begin
                if (cc >= w) begin
                    bundle.recs[n] = '{start: tlwi_pkg::to_start(cs), len: cc, fin: 1'b0};
                    n  = n + 2'd1;
                    cs = tlwi_pkg::sat_add(cs, tlwi_pkg::offset_t'(cc));
                    cc = 8'd0;
                end
                cc = cc + 8'd1;
            end
            if (in_eof) begin
                bundle.recs[n] = '{start: tlwi_pkg::to_start(cs), len: cc, fin: 1'b1};
                n = n + 2'd1;
            end
        end

        bundle.count     = n;
        chunk_start_next = cs;
        chunk_count_next = cc;
        lines_next       = lines_reg + tlwi_pkg::LNUM_BITS'(n);

        // end of file: everything but the width returns to zero
        if (in_eof) begin
            chunk_start_next = '0;
            byte_offset_next = '0;
            chunk_count_next = 8'd0;
            cr_held_next     = 1'b0;
            lines_next       = '0;
        end
    end

    assign push        = accept && (bundle.count != 2'd0);
    assign push_bundle = bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= tlwi_pkg::WIDTH_RESET;
            chunk_start_reg <= '0;
            byte_offset_reg <= '0;
            chunk_count_reg <= 8'd0;
            cr_held_reg     <= 1'b0;
            lines_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                width_reg <= cfg_data;
            end
            if (accept) begin
                chunk_start_reg <= chunk_start_next;
                byte_offset_reg <= byte_offset_next;
                chunk_count_reg <= chunk_count_next;
                cr_held_reg     <= cr_held_next;
                lines_reg       <= lines_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/tlwi_queue.sv
// Short bundle queue between front and back end.
// Uses tlwi_pkg for the bundle type and depth.
`default_nettype none

module tlwi_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire tlwi_pkg::bundle_t push_bundle,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output tlwi_pkg::bundle_t      head
);

    tlwi_pkg::bundle_t                entries [tlwi_pkg::QUEUE_DEPTH];
    logic [tlwi_pkg::QPTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [tlwi_pkg::QPTR_BITS:0]     fill_reg, fill_next;

    assign full  = (fill_reg == (tlwi_pkg::QPTR_BITS+1)'(tlwi_pkg::QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entries[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !(pop && !empty)) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && pop && !empty) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/tlwi_back.sv
// Back end: walks the records of the head bundle one at a time into the
// output register. Uses tlwi_pkg.
`default_nettype none

module tlwi_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire tlwi_pkg::bundle_t head,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [47:0]            m_tdata,
    output logic                   m_tlast
);

    logic [1:0]                      idx_reg;
    logic                            valid_reg;
    logic [tlwi_pkg::START_BITS-1:0] start_reg;
    logic [tlwi_pkg::LEN_BITS-1:0]   len_reg;
    logic [tlwi_pkg::LNUM_BITS-1:0]  lnum_reg;
    logic                            fin_reg;
    logic                            load;
    logic                            last_rec;
    tlwi_pkg::rec_t                  rec;

    assign load     = !q_empty && (!valid_reg || m_tready);
    assign rec      = head.recs[idx_reg];
    assign last_rec = (idx_reg == (head.count - 2'd1));
    assign pop      = load && last_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= last_rec ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            start_reg <= rec.start;
            len_reg   <= rec.len;
            fin_reg   <= rec.fin;
            lnum_reg  <= head.base + tlwi_pkg::LNUM_BITS'(idx_reg);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {lnum_reg, len_reg, start_reg};
    assign m_tlast  = fin_reg;

endmodule

`default_nettype wire

>>> sv/text_line_wrap_indexer_unit.sv
// Text line wrap indexer: byte stream in, display-line records out.
// Built from tlwi_front, tlwi_queue and tlwi_back; types from tlwi_pkg.
//
// Usage:
//  - s_ channel: one file byte per transfer, s_tlast on the final byte.
//  - m_ channel: one record per display line: start offset, length and
//    line number in m_tdata, m_tlast on the file's last line.
//  - cfg channel: writes the line width (0 acts as 1); only while idle.
// Path: the first record of a byte is written into the queue, then loaded
// into the output register that drives m_.
// Throughput: one byte per cycle while each byte causes at most one
// record and m_tready stays high; the output register drains one record per
// cycle while m_tready is high; a byte after a held CR gives up to 3 records.
// A four-entry bundle queue decouples the two ends; s_tready drops only
// when that queue is full, which happens when m_tready is held low or
// records outrun bytes.
// Reset: width returns to 41, offsets, line count and queue are cleared.
// After the final byte the stream state also clears for the next file.
`default_nettype none

module text_line_wrap_indexer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration: line width
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    // input bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // end_of_file
    // display-line records
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [19:0] line_start, [27:20] line_len,
                                        // [47:28] line_number
    output logic             m_tlast    // final_line
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    tlwi_pkg::bundle_t push_bundle;
    tlwi_pkg::bundle_t head;

    tlwi_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_byte     (s_tdata),
        .in_eof      (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    tlwi_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .empty       (q_empty),
        .head        (head)
    );

    tlwi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> sim/tb_text_line_wrap_indexer_unit.sv
// Self-checking bench for text_line_wrap_indexer_unit: feeds bytes, checks line records.
// Needs tlwi_pkg (sv/tlwi_pkg.sv) and the unit itself; nothing else is read.
// A local wrap model predicts each record; directed files, then random files.
module tb_text_line_wrap_indexer_unit;

    localparam int STALL_LIMIT = 4000;  // cycles with no transfer at all
    localparam int SETTLE      = 12;    // quiet cycles before a width write
    localparam int HOLD_CYCLES = 300;   // one long receiver hold-off
    localparam int RAND_ITEMS  = 64;    // per random phase, six phases

    typedef enum logic [1:0] {PH_DIRECTED, PH_RANDOM} stim_phase_t;

    typedef struct packed {
        logic [7:0] text;
        logic       eof;
    } text_item_t;

    typedef struct packed {
        logic [tlwi_pkg::START_BITS-1:0] start;
        logic [tlwi_pkg::LEN_BITS-1:0]   len;
        logic [tlwi_pkg::LNUM_BITS-1:0]  lnum;
        logic                            fin;
    } line_rec_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    text_line_wrap_indexer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    text_item_t  file_bytes_q[$];
    line_rec_t   expected_lines[$];
    stim_phase_t stim_phase   = PH_DIRECTED;
    bit          no_idle      = 1'b0;
    int          mismatches   = 0;
    int          lines_checked = 0;
    int          hold_mark    = 0;
    int          quiet_cycles = 0;

    // wrap model state
    logic [7:0]                       wrap_width = tlwi_pkg::WIDTH_RESET;
    logic [tlwi_pkg::OFFSET_BITS-1:0] open_start = '0;
    logic [tlwi_pkg::OFFSET_BITS-1:0] file_pos   = '0;
    int unsigned                      open_len   = 0;
    bit                               cr_pending = 1'b0;
    logic [tlwi_pkg::LNUM_BITS-1:0]   lines_out  = '0;

    function automatic logic [tlwi_pkg::OFFSET_BITS-1:0] pos_add(
            input logic [tlwi_pkg::OFFSET_BITS-1:0] a, input int unsigned b);
        longint unsigned s;
        s = a;
        s += b;
        if (s > tlwi_pkg::OFFSET_MAX)
            s = tlwi_pkg::OFFSET_MAX;
        return s[tlwi_pkg::OFFSET_BITS-1:0];
    endfunction

    function automatic void push_line(input logic [tlwi_pkg::OFFSET_BITS-1:0] start,
                                      input int unsigned len, input bit fin);
        line_rec_t r;
        r.start = start[tlwi_pkg::START_BITS-1:0];
        r.len   = tlwi_pkg::LEN_BITS'(len);
        r.lnum  = lines_out;
        r.fin   = fin;
        expected_lines.push_back(r);
        lines_out = lines_out + 1'b1;
    endfunction

    function automatic void add_char();
        int unsigned lim;
        lim = (wrap_width == 8'd0) ? 1 : wrap_width;
        if (open_len >= lim) begin
            push_line(open_start, open_len, 1'b0);
            open_start = pos_add(open_start, open_len);
            open_len   = 0;
        end
        open_len++;
    endfunction

    function automatic void restart_file();
        open_start = '0;
        file_pos   = '0;
        open_len   = 0;
        cr_pending = 1'b0;
        lines_out  = '0;
    endfunction

    // lines completed by one accepted byte
    function automatic void index_byte(input text_item_t it);
        if (it.text == tlwi_pkg::CH_LF) begin
            cr_pending = 1'b0;
            push_line(open_start, open_len, it.eof);
            open_start = pos_add(file_pos, 1);
            open_len   = 0;
            if (it.eof) begin
                restart_file();
                return;
            end
        end else begin
            // a CR not followed by LF is an ordinary character
            if (cr_pending) begin
                add_char();
                cr_pending = 1'b0;
            end
            if (it.text == tlwi_pkg::CH_CR) begin
                if (!it.eof)
                    cr_pending = 1'b1;
            end else begin
                add_char();
            end
            if (it.eof) begin
                push_line(open_start, open_len, 1'b1);
                restart_file();
                return;
            end
        end
        file_pos = pos_add(file_pos, 1);
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 50)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // sender
    text_item_t  offered;
    int unsigned tx_gap = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                index_byte(offered);
                tx_gap = no_idle ? 0 : idle_len();
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (file_bytes_q.size() > 0) begin
                    offered = file_bytes_q.pop_front();
                    s_tdata  <= offered.text;
                    s_tlast  <= offered.eof;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    int unsigned rx_gap    = 0;
    int unsigned hold_left = 0;
    bit          held_once = 1'b0;

    always @(posedge aclk) begin : rx_side
        line_rec_t got;
        line_rec_t want;
        bit        ready_next;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.start = m_tdata[19:0];
                got.len   = m_tdata[27:20];
                got.lnum  = m_tdata[47:28];
                got.fin   = m_tlast;
                if (expected_lines.size() == 0) begin
                    report_mismatch("line record with none pending", got, 0);
                end else begin
                    want = expected_lines.pop_front();
                    if (got.start !== want.start)
                        report_mismatch("line_start", got.start, want.start);
                    if (got.len !== want.len)
                        report_mismatch("line_len", got.len, want.len);
                    if (got.lnum !== want.lnum)
                        report_mismatch("line_number", got.lnum, want.lnum);
                    if (got.fin !== want.fin)
                        report_mismatch("final_line", got.fin, want.fin);
                end
                lines_checked++;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stim_phase == PH_RANDOM && !held_once && lines_checked >= hold_mark) begin
                // long back-pressure so the unit fills up and stalls s_
                held_once  = 1'b1;
                hold_left  = HOLD_CYCLES - 1;
                ready_next = 1'b0;
            end else if (no_idle) begin
                ready_next = 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap--;
                ready_next = 1'b0;
            end else begin
                rx_gap = idle_len();
                ready_next = (rx_gap == 0);
                if (rx_gap > 0)
                    rx_gap--;
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put(input logic [7:0] b, input bit eof = 1'b0);
        text_item_t it;
        it.text = b;
        it.eof  = eof;
        file_bytes_q.push_back(it);
    endtask

    // every byte taken, every line out, then a few quiet cycles
    task automatic drain();
        @(negedge aclk);
        while (file_bytes_q.size() != 0 || s_tvalid || expected_lines.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_width(input logic [7:0] w);
        @(posedge aclk);
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        wrap_width = w;
    endtask

    task automatic queue_random(input int count);
        int k;
        int r;
        k = 0;
        while (k < count) begin
            r = $urandom_range(99);
            if (r < 8) begin
                put(tlwi_pkg::CH_LF, $urandom_range(99) < 3);
            end else if (r < 12) begin
                put(tlwi_pkg::CH_CR, $urandom_range(99) < 5);
            end else if (r < 17) begin
                put(tlwi_pkg::CH_CR);
                put(tlwi_pkg::CH_LF, $urandom_range(99) < 4);
                k++;
            end else if (r < 20) begin
                put(8'h00, $urandom_range(99) < 3);
            end else if (r < 80) begin
                put(8'($urandom_range(8'h20, 8'h7E)), $urandom_range(99) < 3);
            end else begin
                put(8'($urandom_range(255)), $urandom_range(99) < 3);
            end
            k++;
        end
    endtask

    initial begin : stimulus
        logic [7:0] rand_widths[6];
        int i;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // reset width: NUL and 0xFF as text, CR before a char, CR LF, empty line, CR at eof
        put(8'h00); put(8'hFF); put("a"); put(tlwi_pkg::CH_CR); put("b");
        put(tlwi_pkg::CH_CR); put(tlwi_pkg::CH_LF); put(tlwi_pkg::CH_LF); put("c");
        put(tlwi_pkg::CH_CR, 1'b1);
        drain();
        // segment an exact multiple of the width, then a non-LF last byte
        set_width(8'd2);
        put("a"); put("b"); put("c"); put("d"); put(tlwi_pkg::CH_LF); put("e", 1'b1);
        drain();
        // held CR followed by a char gives three lines from one byte
        set_width(8'd1);
        put("a"); put(tlwi_pkg::CH_CR); put("x", 1'b1);
        drain();
        // width zero acts as one; LF as last byte
        set_width(8'd0);
        put("p"); put("q"); put(tlwi_pkg::CH_LF, 1'b1);
        drain();
        // width lowered under an open chunk
        set_width(8'd8);
        for (i = 0; i < 6; i++)
            put(8'($urandom_range(8'h21, 8'h7E)));
        drain();
        set_width(8'd2);
        put("z"); put(tlwi_pkg::CH_CR); put(tlwi_pkg::CH_LF, 1'b1);
        drain();

        rand_widths[0] = 8'd3;
        rand_widths[1] = 8'd255;
        rand_widths[2] = 8'd1;
        rand_widths[3] = 8'($urandom_range(2, 20));
        rand_widths[4] = 8'd0;
        rand_widths[5] = 8'($urandom_range(21, 254));
        hold_mark = lines_checked + 3;
        stim_phase = PH_RANDOM;
        for (i = 0; i < 6; i++) begin
            set_width(rand_widths[i]);
            no_idle = (i == 2);
            queue_random(RAND_ITEMS);
            drain();
        end
        no_idle = 1'b0;

        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> files.f
sv/tlwi_pkg.sv
sv/tlwi_front.sv
sv/tlwi_queue.sv
sv/tlwi_back.sv
sv/text_line_wrap_indexer_unit.sv
sim/tb_text_line_wrap_indexer_unit.sv
